[rtl/core/lpe_pkg.sv]
// Shared types and constants of the LSB pattern extractor.
`timescale 1ns / 1ps

package lpe_pkg;

    localparam int LIMIT_BITS = 32;
    localparam int HEADER_LEN = 4;

    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;

    localparam logic [1:0] CFG_STOP_MODE   = 2'd0;
    localparam logic [1:0] CFG_BYTE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_START_PHASE = 2'd2;

    localparam logic STOP_COUNT = 1'b0;
    localparam logic STOP_ZERO  = 1'b1;

    localparam logic STATUS_PAYLOAD   = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    typedef struct packed {
        logic        stop_mode;
        logic [31:0] byte_limit;
        logic [1:0]  start_phase;
    } t_cfg;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       last_in;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       last_out;
        logic       status;
    } t_result;

endpackage

[rtl/core/lsbi_pattern_extractor_unit.sv]
// Top level of the LSB pattern extractor: stream ports, configuration and word registers.
`timescale 1ns / 1ps

// The slave stream takes one image pixel byte per word in blue, green, red
// order, with s_axis_tlast on the final byte of an image. The master stream
// returns extracted payload bytes; m_axis_tlast marks the last result of an
// extraction and m_axis_tuser flags an image that ended before extraction
// was complete (data is then zero). Most input words give no result.
// The configuration channel writes stop mode (index 0), byte limit (index 1)
// and start phase (index 2); it is always ready and should only be used
// while no words are in flight.
// An accepted word is held in an input register and processed from there
// when the output register is free or being drained, and its result is
// loaded into the output register. One word is accepted every cycle as
// long as the output register is free or being drained.
// When the receiver stalls, the output register holds its word, the input
// register fills, and s_axis_tready falls until the output is taken.
// Reset clears both registers, restarts image extraction and loads the
// configuration defaults: count mode, limit zero, green start phase.

module lsbi_pattern_extractor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] image_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    lpe_pkg::t_cfg    r_cfg;
    lpe_pkg::t_item   r_in;
    logic             r_in_valid;
    lpe_pkg::t_result r_out;
    logic             r_out_valid;
    lpe_pkg::t_result result;
    logic             step;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.payload_byte;
    assign m_axis_tlast  = r_out.last_out;
    assign m_axis_tuser  = r_out.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_mode   <= lpe_pkg::STOP_COUNT;
            r_cfg.byte_limit  <= 32'd0;
            r_cfg.start_phase <= lpe_pkg::PHASE_GREEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lpe_pkg::CFG_STOP_MODE:   r_cfg.stop_mode   <= i_cfg_data[0];
                lpe_pkg::CFG_BYTE_LIMIT:  r_cfg.byte_limit  <= i_cfg_data;
                lpe_pkg::CFG_START_PHASE: r_cfg.start_phase <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.image_byte <= s_axis_tdata;
            r_in.last_in    <= s_axis_tlast;
        end
    end

    lpe_extract u_extract (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= result.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_out <= result;
        end
    end

endmodule

[rtl/core/lpe_extract.sv]
// Extraction state and the single-pass next-state and result logic.
`timescale 1ns / 1ps

module lpe_extract (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  lpe_pkg::t_item   i_item,
    input  lpe_pkg::t_cfg    i_cfg,
    output lpe_pkg::t_result o_result
);

    logic [3:0]                     r_mask_bits,    n_mask_bits;
    logic [2:0]                     r_header_count, n_header_count;
    logic [1:0]                     r_colour_phase, n_colour_phase;
    logic [2:0]                     r_bit_count,    n_bit_count;
    logic [7:0]                     r_shift_reg,    n_shift_reg;
    logic [lpe_pkg::LIMIT_BITS-1:0] r_bytes_done,   n_bytes_done;
    logic                           r_finished,     n_finished;

    logic [lpe_pkg::LIMIT_BITS-1:0] limit;
    logic [lpe_pkg::LIMIT_BITS-1:0] done_inc;
    logic                           done_now;
    logic                           done_after;
    logic                           data_bit;
    logic [7:0]                     shifted;
    logic                           final_word;

    assign limit    = i_cfg.byte_limit[lpe_pkg::LIMIT_BITS-1:0];
    assign done_now = r_finished ||
                      (i_cfg.stop_mode == lpe_pkg::STOP_COUNT && r_bytes_done >= limit);
    assign done_inc = (r_bytes_done == {lpe_pkg::LIMIT_BITS{1'b1}}) ?
                      r_bytes_done : r_bytes_done + 1'b1;
    assign data_bit = i_item.image_byte[0] ^ r_mask_bits[i_item.image_byte[2:1]];
    assign shifted  = {r_shift_reg[6:0], data_bit};
    assign final_word = (i_cfg.stop_mode == lpe_pkg::STOP_ZERO) ?
                        (shifted == 8'd0) : (done_inc >= limit);

    always_comb begin
        n_mask_bits    = r_mask_bits;
        n_header_count = r_header_count;
        n_colour_phase = r_colour_phase;
        n_bit_count    = r_bit_count;
        n_shift_reg    = r_shift_reg;
        n_bytes_done   = r_bytes_done;
        n_finished     = r_finished;
        o_result       = '0;

        if (!done_now) begin
            if (r_header_count < 3'(lpe_pkg::HEADER_LEN)) begin
                n_mask_bits    = r_mask_bits |
                                 (4'(i_item.image_byte[0]) << r_header_count[1:0]);
                n_header_count = r_header_count + 3'd1;
                if (r_header_count == 3'(lpe_pkg::HEADER_LEN - 1)) begin
                    n_colour_phase = i_cfg.start_phase;
                end
            end else begin
                n_colour_phase = (r_colour_phase >= lpe_pkg::PHASE_RED) ?
                                 lpe_pkg::PHASE_BLUE : r_colour_phase + 2'd1;
                if (r_colour_phase != lpe_pkg::PHASE_RED) begin
                    if (r_bit_count == 3'd7) begin
                        n_bit_count           = 3'd0;
                        n_shift_reg           = 8'd0;
                        n_bytes_done          = done_inc;
                        n_finished            = final_word;
                        o_result.valid        = 1'b1;
                        o_result.payload_byte = shifted;
                        o_result.last_out     = final_word;
                        o_result.status       = lpe_pkg::STATUS_PAYLOAD;
                    end else begin
                        n_bit_count = r_bit_count + 3'd1;
                        n_shift_reg = shifted;
                    end
                end
            end
        end

        done_after = n_finished ||
                     (i_cfg.stop_mode == lpe_pkg::STOP_COUNT && n_bytes_done >= limit);

        if (i_item.last_in) begin
            if (!done_after) begin
                o_result.valid        = 1'b1;
                o_result.payload_byte = 8'd0;
                o_result.last_out     = 1'b1;
                o_result.status       = lpe_pkg::STATUS_EXHAUSTED;
            end
            n_mask_bits    = 4'd0;
            n_header_count = 3'd0;
            n_colour_phase = i_cfg.start_phase;
            n_bit_count    = 3'd0;
            n_shift_reg    = 8'd0;
            n_bytes_done   = '0;
            n_finished     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_bits    <= 4'd0;
            r_header_count <= 3'd0;
            r_colour_phase <= lpe_pkg::PHASE_GREEN;
            r_bit_count    <= 3'd0;
            r_shift_reg    <= 8'd0;
            r_bytes_done   <= '0;
            r_finished     <= 1'b0;
        end else if (i_step) begin
            r_mask_bits    <= n_mask_bits;
            r_header_count <= n_header_count;
            r_colour_phase <= n_colour_phase;
            r_bit_count    <= n_bit_count;
            r_shift_reg    <= n_shift_reg;
            r_bytes_done   <= n_bytes_done;
            r_finished     <= n_finished;
        end
    end

    // Payload bits are only collected once the whole mask header is in.
    a_bits_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count != 3'd0 |-> r_header_count == 3'(lpe_pkg::HEADER_LEN))
        else $error("payload bits collected during header");

    a_clear_between_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count == 3'd0 |-> r_shift_reg == 8'd0)
        else $error("shift register not cleared at word boundary");

    a_finish_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> r_header_count == 3'(lpe_pkg::HEADER_LEN))
        else $error("extraction finished before the header was read");

    a_restart_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_in |=> r_header_count == 3'd0 && r_bytes_done == '0)
        else $error("state not restarted after the final image word");

endmodule

[bench/lsbi_pattern_extractor_unit_tb.sv]
// Testbench of the LSB pattern extractor: random image streams checked against a built-in predictor.
`timescale 1ns / 1ps

module lsbi_pattern_extractor_unit_tb;

    localparam logic [1:0] PHASE_THREE = 2'd3;
    localparam int TOTAL_WORDS = 1450;
    localparam int QUIET_FROM = 1250;
    localparam int PHASE_WORDS = 110;
    localparam int STALL_LIMIT = 1000;

    class lsbi_scoreboard;
        logic             stop_mode;
        logic [31:0]      byte_limit;
        logic [1:0]       start_phase;
        logic [3:0]       mask_bits;
        int               header_count;
        logic [1:0]       colour_phase;
        int               bit_count;
        logic [7:0]       shift_reg;
        logic [31:0]      bytes_done;
        bit               finished;
        lpe_pkg::t_result pending_payloads[$];
        int               failures;

        function new();
            stop_mode = lpe_pkg::STOP_COUNT;
            byte_limit = '0;
            start_phase = lpe_pkg::PHASE_GREEN;
            failures = 0;
            restart_image();
        endfunction

        function void restart_image();
            mask_bits = '0;
            header_count = 0;
            colour_phase = start_phase;
            bit_count = 0;
            shift_reg = '0;
            bytes_done = '0;
            finished = 1'b0;
        endfunction

        function bit complete();
            return finished ||
                   (stop_mode == lpe_pkg::STOP_COUNT && bytes_done >= byte_limit);
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] data);
            case (index)
                lpe_pkg::CFG_STOP_MODE: stop_mode = data[0];
                lpe_pkg::CFG_BYTE_LIMIT: byte_limit = data;
                lpe_pkg::CFG_START_PHASE: start_phase = data[1:0];
                default: ;
            endcase
        endfunction

        function void note_byte(lpe_pkg::t_item word);
            lpe_pkg::t_result res;
            bit               red;
            res = '0;
            if (!complete()) begin
                if (header_count < lpe_pkg::HEADER_LEN) begin
                    mask_bits[header_count] = word.image_byte[0];
                    header_count++;
                    if (header_count == lpe_pkg::HEADER_LEN) begin
                        colour_phase = start_phase;
                    end
                end else begin
                    red = (colour_phase == lpe_pkg::PHASE_RED);
                    colour_phase = (colour_phase >= lpe_pkg::PHASE_RED) ?
                                   lpe_pkg::PHASE_BLUE : colour_phase + 2'd1;
                    if (!red) begin
                        shift_reg = {shift_reg[6:0],
                                     word.image_byte[0] ^ mask_bits[word.image_byte[2:1]]};
                        if (bit_count == 7) begin
                            bit_count = 0;
                            if (bytes_done != '1) begin
                                bytes_done++;
                            end
                            res.valid = 1'b1;
                            res.payload_byte = shift_reg;
                            res.status = lpe_pkg::STATUS_PAYLOAD;
                            res.last_out = (stop_mode == lpe_pkg::STOP_ZERO) ?
                                           (shift_reg == 8'h00) : (bytes_done >= byte_limit);
                            finished = res.last_out;
                            shift_reg = '0;
                        end else begin
                            bit_count++;
                        end
                    end
                end
            end
            if (word.last_in) begin
                if (!complete()) begin
                    res.valid = 1'b1;
                    res.payload_byte = '0;
                    res.last_out = 1'b1;
                    res.status = lpe_pkg::STATUS_EXHAUSTED;
                end
                restart_image();
            end
            if (res.valid) begin
                pending_payloads.push_back(res);
            end
        endfunction

        function void check_payload(logic [7:0] data, logic last, logic status);
            lpe_pkg::t_result exp;
            if (pending_payloads.size() == 0) begin
                $display("%0t: unexpected word data %h last %b status %b",
                         $time, data, last, status);
                failures++;
                return;
            end
            exp = pending_payloads.pop_front();
            if (data !== exp.payload_byte) begin
                $display("%0t: payload byte expected %h actual %h",
                         $time, exp.payload_byte, data);
                failures++;
            end
            if (last !== exp.last_out) begin
                $display("%0t: last expected %b actual %b", $time, exp.last_out, last);
                failures++;
            end
            if (status !== exp.status) begin
                $display("%0t: status expected %b actual %b", $time, exp.status, status);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    lsbi_scoreboard sb = new();
    lpe_pkg::t_item image_words[$];
    int             words_sent = 0;
    int             phase_words = 0;
    bit             quiet = 1'b0;
    int             stall_left = 0;
    int             idle_cycles = 0;

    lsbi_pattern_extractor_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(negedge i_clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(5) == 0) begin
            stall_left = $urandom_range(1, 3);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_payload(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("lsbi_pattern_extractor_unit test failed");
            $finish;
        end
    end

    function automatic void push_word(logic [7:0] b);
        lpe_pkg::t_item word;
        word.image_byte = b;
        word.last_in = 1'b0;
        image_words.push_back(word);
    endfunction

    function automatic void mark_last();
        image_words[image_words.size() - 1].last_in = 1'b1;
    endfunction

    // Encodes random payload bytes so that the extractor recovers them under
    // the current start phase; red bytes carry random filler.
    function automatic void build_image(int n_payload, bit zero_end, int tail);
        logic [3:0] mask;
        logic [1:0] phase;
        logic [7:0] value;
        logic [7:0] b;
        image_words.delete();
        for (int i = 0; i < lpe_pkg::HEADER_LEN; i++) begin
            b = $urandom;
            mask[i] = b[0];
            push_word(b);
        end
        phase = sb.start_phase;
        for (int p = 0; p < n_payload; p++) begin
            if (zero_end && p == n_payload - 1) begin
                value = 8'h00;
            end else if (zero_end) begin
                value = 8'($urandom_range(1, 255));
            end else begin
                value = $urandom;
            end
            for (int k = 7; k >= 0; k--) begin
                if (phase == lpe_pkg::PHASE_RED) begin
                    push_word($urandom);
                    phase = lpe_pkg::PHASE_BLUE;
                end
                b = $urandom;
                b[0] = value[k] ^ mask[b[2:1]];
                push_word(b);
                phase = (phase >= lpe_pkg::PHASE_RED) ? lpe_pkg::PHASE_BLUE : phase + 2'd1;
            end
        end
        repeat (tail) push_word($urandom);
        mark_last();
    endfunction

    function automatic void build_noise(int len);
        image_words.delete();
        repeat (len) push_word($urandom);
        mark_last();
    endfunction

    task automatic send_word(lpe_pkg::t_item word);
        bit taken;
        if (!quiet && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word.image_byte;
        s_axis_tlast <= word.last_in;
        do begin
            @(posedge i_clk);
            taken = s_axis_tready;
            if (taken) begin
                sb.note_byte(word);
            end
            @(negedge i_clk);
        end while (!taken);
        words_sent++;
        phase_words++;
        if (words_sent >= QUIET_FROM) begin
            quiet = 1'b1;
        end
    endtask

    task automatic send_image();
        foreach (image_words[i]) begin
            send_word(image_words[i]);
        end
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
            taken = o_cfg_ready;
            if (taken) begin
                sb.write_reg(index, data);
            end
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic set_config(logic mode, logic [31:0] limit, logic [1:0] phase);
        write_reg(lpe_pkg::CFG_STOP_MODE, {31'd0, mode});
        write_reg(lpe_pkg::CFG_BYTE_LIMIT, limit);
        write_reg(lpe_pkg::CFG_START_PHASE, {30'd0, phase});
        i_cfg_valid <= 1'b0;
    endtask

    // Items that give no result may still sit in the pipeline, so the bench
    // keeps waiting after the last expected word.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_payloads.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int n_payload;
        int kind;
        int cut;
        int phase_idx;
        bit zero_mode;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults select count mode with a zero limit: nothing comes out.
        image_words.delete();
        push_word(8'h00);
        push_word(8'hFF);
        push_word(8'h80);
        push_word(8'h7F);
        mark_last();
        send_image();
        drain();
        set_config(lpe_pkg::STOP_ZERO, 32'd0, lpe_pkg::PHASE_BLUE);
        build_noise(1);
        send_image();
        build_image(1, 1'b1, 1);
        send_image();
        drain();

        phase_idx = 0;
        while (words_sent < TOTAL_WORDS) begin
            case (phase_idx % 8)
                0: set_config(lpe_pkg::STOP_COUNT, 32'd1, lpe_pkg::PHASE_BLUE);
                1: set_config(lpe_pkg::STOP_ZERO, 32'hFFFF_FFFF, lpe_pkg::PHASE_RED);
                2: set_config(lpe_pkg::STOP_COUNT, 32'hFFFF_FFFF, PHASE_THREE);
                3: set_config(lpe_pkg::STOP_COUNT, 32'd0, lpe_pkg::PHASE_GREEN);
                4: set_config(lpe_pkg::STOP_ZERO, 32'd0, PHASE_THREE);
                default: set_config(1'($urandom_range(1)), 32'($urandom_range(1, 4)),
                                    2'($urandom_range(3)));
            endcase
            zero_mode = (sb.stop_mode == lpe_pkg::STOP_ZERO);
            phase_words = 0;
            while (phase_words < PHASE_WORDS && words_sent < TOTAL_WORDS) begin
                if (!zero_mode && sb.byte_limit != 0 && sb.byte_limit <= 4) begin
                    n_payload = sb.byte_limit;
                end else begin
                    n_payload = $urandom_range(1, 3);
                end
                kind = $urandom_range(9);
                if (kind <= 7) begin
                    build_image(n_payload, zero_mode, $urandom_range(0, 3));
                    if (kind >= 6) begin
                        cut = $urandom_range(1, image_words.size());
                        while (image_words.size() > cut) void'(image_words.pop_back());
                        mark_last();
                    end
                end else if (kind == 8) begin
                    build_noise($urandom_range(1, 24));
                end else begin
                    build_noise($urandom_range(1, lpe_pkg::HEADER_LEN));
                end
                send_image();
            end
            drain();
            phase_idx++;
        end

        if (sb.failures == 0) begin
            $display("lsbi_pattern_extractor_unit test passed");
        end else begin
            $display("lsbi_pattern_extractor_unit test failed");
        end
        $finish;
    end

endmodule
